[hdl/gte_pkg.sv]
`timescale 1ns / 1ps

package gte_pkg;

   localparam int ROWS     = 10;
   localparam int COLS     = 10;
   localparam int CELLS    = ROWS * COLS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int LINE_MAX = (ROWS > COLS) ? ROWS : COLS;
   localparam int IDX_W    = 4;
   localparam int VAL_W    = 16;
   localparam int RES_W    = 23;
   localparam int MASK_W   = 16;
   localparam int ACC_W    = 26;
   localparam int TENTHS   = 10;

   typedef enum logic [2:0] {
      CMD_SET, CMD_CLEAR, CMD_SUM, CMD_SEARCH, CMD_SORT, CMD_MEAN, CMD_MIN, CMD_MAX
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_CLEAR, OP_SUM, OP_FIRST, OP_MIN, OP_MAX, OP_MATCH, OP_LANE
   } op_type;

   typedef enum logic [2:0] {
      EMIT_ERR, EMIT_OK, EMIT_ACC, EMIT_MEAN, EMIT_MASK, EMIT_LANE
   } emit_type;

   typedef struct packed {
      logic                    wr;
      logic                    rd;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] wdata;
      op_type                  op;
      logic                    lane_clear;
      logic                    sort_step;
      logic                    sort_odd;
      logic                    desc;
      logic                    line_col;
      logic                    emit;
      emit_type                kind;
      logic [IDX_W-1:0]        pos;
      logic                    last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_ready;
   } dp_status_type;

endpackage

[hdl/gte_ram.sv]
`timescale 1ns / 1ps

module gte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/gte_datapath.sv]
`timescale 1ns / 1ps

module gte_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gte_pkg::dp_cmd_type                    cmd,
   output gte_pkg::dp_status_type                 status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_status,
   output logic signed [gte_pkg::RES_W-1:0]       rsp_result_value,
   output logic [gte_pkg::IDX_W-1:0]              rsp_position,
   output logic [gte_pkg::MASK_W-1:0]             rsp_match_mask,
   output logic                                   rsp_last
);

   localparam int PROD_W = gte_pkg::ACC_W + 4;
   localparam int LM     = gte_pkg::LINE_MAX;
   localparam logic signed [PROD_W-1:0] RV_HI = PROD_W'(2 ** (gte_pkg::RES_W - 1) - 1);
   localparam logic signed [PROD_W-1:0] RV_LO = -RV_HI - PROD_W'(1);
   localparam int MAG_W  = gte_pkg::RES_W + 1;
   localparam int RCP_SH = MAG_W + 4;
   localparam int RCP_W  = RCP_SH;
   localparam int MUL_W  = MAG_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP_ROWS =
      RCP_W'((2 ** RCP_SH + gte_pkg::ROWS - 1) / gte_pkg::ROWS);
   localparam logic [RCP_W-1:0] RCP_COLS =
      RCP_W'((2 ** RCP_SH + gte_pkg::COLS - 1) / gte_pkg::COLS);

   function automatic logic signed [gte_pkg::RES_W-1:0] sat_res(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v;
      if (v > RV_HI) begin
         t = RV_HI;
      end else if (v < RV_LO) begin
         t = RV_LO;
      end
      return t[gte_pkg::RES_W-1:0];
   endfunction

   logic [gte_pkg::ADDR_W-1:0]        addr;
   logic [gte_pkg::VAL_W-1:0]         ram_q;
   logic [gte_pkg::CELLS-1:0]         vld_ff;
   logic                              vld_rd_ff;
   gte_pkg::op_type                   op_d_ff;
   logic [gte_pkg::IDX_W-1:0]         col_d_ff;
   logic signed [gte_pkg::VAL_W-1:0]  val_d_ff;
   logic signed [gte_pkg::VAL_W-1:0]  x;
   logic signed [gte_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [gte_pkg::MASK_W-1:0]        mask_ff, mask_in;
   logic signed [gte_pkg::VAL_W-1:0]  lane_ff [LM];
   logic signed [gte_pkg::VAL_W-1:0]  lane_in [LM];
   logic [LM-1:0]                     lane_v_ff, lane_v_in;
   logic signed [gte_pkg::ACC_W-1:0]  x_ext;
   logic signed [PROD_W-1:0]          prod, mean_v;
   logic [MAG_W-1:0]                  prod_mag;
   logic [RCP_W-1:0]                  rcp;
   logic [MUL_W-1:0]                  quot_full;
   logic [MAG_W-1:0]                  quot;
   logic                              out_ready;
   logic                              rsp_valid_ff;
   logic                              rsp_status_ff;
   logic signed [gte_pkg::RES_W-1:0]  rsp_value_ff;
   logic [gte_pkg::IDX_W-1:0]         rsp_pos_ff;
   logic [gte_pkg::MASK_W-1:0]        rsp_mask_ff;
   logic                              rsp_last_ff;

   assign addr = gte_pkg::ADDR_W'(int'(cmd.row) * gte_pkg::COLS + int'(cmd.col));

   gte_ram #(
      .WIDTH(gte_pkg::VAL_W),
      .DEPTH(gte_pkg::CELLS)
   ) u_cells (
      .clock(clock),
      .we   (cmd.wr),
      .addr (addr),
      .wdata(cmd.wdata),
      .rdata(ram_q)
   );

   assign x     = vld_rd_ff ? $signed(ram_q) : '0;
   assign x_ext = gte_pkg::ACC_W'(x);

   always_comb begin
      acc_in  = acc_ff;
      mask_in = mask_ff;
      case (op_d_ff)
         gte_pkg::OP_CLEAR: acc_in = '0;
         gte_pkg::OP_SUM:   acc_in = acc_ff + x_ext;
         gte_pkg::OP_FIRST: acc_in = x_ext;
         gte_pkg::OP_MIN:   acc_in = (x_ext < acc_ff) ? x_ext : acc_ff;
         gte_pkg::OP_MAX:   acc_in = (x_ext > acc_ff) ? x_ext : acc_ff;
         gte_pkg::OP_MATCH: begin
            if (col_d_ff == '0) begin
               mask_in = '0;
            end
            mask_in[col_d_ff] = (x == val_d_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      lane_in   = lane_ff;
      lane_v_in = lane_v_ff;
      if (cmd.lane_clear) begin
         lane_v_in = '0;
      end else if (op_d_ff == gte_pkg::OP_LANE) begin
         for (int i = 0; i < LM - 1; i++) begin
            lane_in[i]   = lane_ff[i + 1];
            lane_v_in[i] = lane_v_ff[i + 1];
         end
         lane_in[LM-1]   = x;
         lane_v_in[LM-1] = 1'b1;
      end else if (cmd.sort_step) begin
         for (int i = 0; i < LM - 1; i++) begin
            if ((i % 2) == int'(cmd.sort_odd)) begin
               if (lane_v_ff[i + 1] && (!lane_v_ff[i] ||
                   (cmd.desc ? (lane_ff[i + 1] > lane_ff[i])
                             : (lane_ff[i + 1] < lane_ff[i])))) begin
                  lane_in[i]       = lane_ff[i + 1];
                  lane_in[i + 1]   = lane_ff[i];
                  lane_v_in[i]     = lane_v_ff[i + 1];
                  lane_v_in[i + 1] = lane_v_ff[i];
               end
            end
         end
      end else if (cmd.emit && cmd.kind == gte_pkg::EMIT_LANE) begin
         for (int i = 0; i < LM - 1; i++) begin
            lane_in[i]   = lane_ff[i + 1];
            lane_v_in[i] = lane_v_ff[i + 1];
         end
         lane_v_in[LM-1] = 1'b0;
      end
   end

   // The line length is a constant, so the mean divides by multiplying the magnitude
   // with a rounded-up reciprocal; this is exact over the whole magnitude range.
   assign prod      = PROD_W'(acc_ff) * $signed(PROD_W'(gte_pkg::TENTHS));
   assign prod_mag  = MAG_W'(prod[PROD_W-1] ? -prod : prod);
   assign rcp       = cmd.line_col ? RCP_ROWS : RCP_COLS;
   assign quot_full = MUL_W'(prod_mag) * MUL_W'(rcp);
   assign quot      = quot_full[RCP_SH +: MAG_W];
   assign mean_v    = prod[PROD_W-1] ? -$signed(PROD_W'(quot)) : $signed(PROD_W'(quot));

   assign out_ready        = !rsp_valid_ff || !rsp_stall;
   assign status.out_ready = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         op_d_ff      <= gte_pkg::OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            vld_ff[addr] <= 1'b1;
         end
         op_d_ff <= cmd.rd ? cmd.op : ((cmd.op == gte_pkg::OP_CLEAR) ? cmd.op
                                                                   : gte_pkg::OP_NONE);
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      vld_rd_ff <= vld_ff[addr];
      col_d_ff  <= cmd.col;
      val_d_ff  <= cmd.wdata;
      acc_ff    <= acc_in;
      mask_ff   <= mask_in;
      lane_ff   <= lane_in;
      lane_v_ff <= lane_v_in;
      if (cmd.emit) begin
         rsp_status_ff <= 1'b0;
         rsp_value_ff  <= '0;
         rsp_pos_ff    <= '0;
         rsp_mask_ff   <= '0;
         rsp_last_ff   <= cmd.last;
         case (cmd.kind)
            gte_pkg::EMIT_ERR:  rsp_status_ff <= 1'b1;
            gte_pkg::EMIT_ACC:  rsp_value_ff  <= sat_res(PROD_W'(acc_ff));
            gte_pkg::EMIT_MEAN: rsp_value_ff  <= sat_res(mean_v);
            gte_pkg::EMIT_MASK: begin
               rsp_mask_ff <= mask_ff;
               rsp_pos_ff  <= cmd.pos;
            end
            gte_pkg::EMIT_LANE: begin
               rsp_value_ff <= gte_pkg::RES_W'(lane_ff[0]);
               rsp_pos_ff   <= cmd.pos;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_match_mask   = rsp_mask_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[hdl/gte_controller.sv]
`timescale 1ns / 1ps

module gte_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_cmd,
   input  logic [gte_pkg::IDX_W-1:0]         req_row_a,
   input  logic [gte_pkg::IDX_W-1:0]         req_col_a,
   input  logic [gte_pkg::IDX_W-1:0]         req_row_b,
   input  logic [gte_pkg::IDX_W-1:0]         req_col_b,
   input  logic [gte_pkg::IDX_W-1:0]         req_line_index,
   input  logic                              req_line_is_column,
   input  logic                              req_descending,
   input  logic signed [gte_pkg::VAL_W-1:0]  req_value,
   input  gte_pkg::dp_status_type            status,
   output gte_pkg::dp_cmd_type               cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_ERR, S_WRITE, S_SCAN, S_DRAIN, S_SORT, S_EMIT, S_LANE
   } state_type;

   localparam logic [gte_pkg::IDX_W-1:0] ROW_LAST  = gte_pkg::IDX_W'(gte_pkg::ROWS - 1);
   localparam logic [gte_pkg::IDX_W-1:0] COL_LAST  = gte_pkg::IDX_W'(gte_pkg::COLS - 1);
   localparam logic [gte_pkg::IDX_W-1:0] SORT_LAST = gte_pkg::IDX_W'(gte_pkg::LINE_MAX - 1);

   state_type                        state_ff;
   gte_pkg::cmd_type                 op_ff;
   logic [gte_pkg::IDX_W-1:0]        ra_ff, ca_ff, rb_ff, cb_ff, li_ff;
   logic                             col_ff, desc_ff;
   logic signed [gte_pkg::VAL_W-1:0] val_ff;
   logic [gte_pkg::IDX_W-1:0]        r_ff, c_ff, k_ff;
   gte_pkg::cmd_type                 req_op;
   logic                             accept, bad, empty_sum, line_bad;
   logic [gte_pkg::IDX_W-1:0]        len_last;

   assign req_op    = gte_pkg::cmd_type'(req_cmd);
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign len_last  = col_ff ? ROW_LAST : COL_LAST;
   assign line_bad  = req_line_is_column ? (int'(req_line_index) >= gte_pkg::COLS)
                                         : (int'(req_line_index) >= gte_pkg::ROWS);
   assign empty_sum = (req_row_a > req_row_b) || (req_col_a > req_col_b);

   always_comb begin
      case (req_op) inside
         gte_pkg::CMD_SET, gte_pkg::CMD_CLEAR:
            bad = (int'(req_row_a) >= gte_pkg::ROWS) || (int'(req_col_a) >= gte_pkg::COLS);
         gte_pkg::CMD_SUM:
            bad = (int'(req_row_a) >= gte_pkg::ROWS) || (int'(req_col_a) >= gte_pkg::COLS) ||
                  (int'(req_row_b) >= gte_pkg::ROWS) || (int'(req_col_b) >= gte_pkg::COLS);
         gte_pkg::CMD_SEARCH: bad = 1'b0;
         default: bad = line_bad;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = gte_pkg::OP_NONE;
      cmd.kind     = gte_pkg::EMIT_OK;
      cmd.desc     = desc_ff;
      cmd.line_col = col_ff;
      cmd.wdata    = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op         = gte_pkg::OP_CLEAR;
               cmd.lane_clear = 1'b1;
            end
         end
         S_ERR: begin
            cmd.emit = status.out_ready;
            cmd.kind = gte_pkg::EMIT_ERR;
            cmd.last = 1'b1;
         end
         S_WRITE: begin
            cmd.emit  = status.out_ready;
            cmd.wr    = status.out_ready;
            cmd.row   = ra_ff;
            cmd.col   = ca_ff;
            cmd.wdata = (op_ff == gte_pkg::CMD_SET) ? val_ff : '0;
            cmd.last  = 1'b1;
         end
         S_SCAN: begin
            cmd.rd = 1'b1;
            case (op_ff) inside
               gte_pkg::CMD_SUM, gte_pkg::CMD_SEARCH: begin
                  cmd.row = r_ff;
                  cmd.col = c_ff;
               end
               default: begin
                  cmd.row = col_ff ? k_ff : li_ff;
                  cmd.col = col_ff ? li_ff : k_ff;
               end
            endcase
            case (op_ff)
               gte_pkg::CMD_SUM, gte_pkg::CMD_MEAN: cmd.op = gte_pkg::OP_SUM;
               gte_pkg::CMD_SEARCH: cmd.op = gte_pkg::OP_MATCH;
               gte_pkg::CMD_SORT:   cmd.op = gte_pkg::OP_LANE;
               gte_pkg::CMD_MIN:
                  cmd.op = (k_ff == '0) ? gte_pkg::OP_FIRST : gte_pkg::OP_MIN;
               gte_pkg::CMD_MAX:
                  cmd.op = (k_ff == '0) ? gte_pkg::OP_FIRST : gte_pkg::OP_MAX;
               default: cmd.op = gte_pkg::OP_NONE;
            endcase
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            cmd.sort_odd  = k_ff[0];
         end
         S_EMIT: begin
            cmd.emit = status.out_ready;
            cmd.last = 1'b1;
            case (op_ff)
               gte_pkg::CMD_MEAN: cmd.kind = gte_pkg::EMIT_MEAN;
               gte_pkg::CMD_SEARCH: begin
                  cmd.kind = gte_pkg::EMIT_MASK;
                  cmd.pos  = r_ff;
                  cmd.last = (r_ff == ROW_LAST);
               end
               default: cmd.kind = gte_pkg::EMIT_ACC;
            endcase
         end
         S_LANE: begin
            cmd.emit = status.out_ready;
            cmd.kind = gte_pkg::EMIT_LANE;
            cmd.pos  = k_ff;
            cmd.last = (k_ff == len_last);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff   <= req_op;
                  ra_ff   <= req_row_a;
                  ca_ff   <= req_col_a;
                  rb_ff   <= req_row_b;
                  cb_ff   <= req_col_b;
                  li_ff   <= req_line_index;
                  col_ff  <= req_line_is_column;
                  desc_ff <= req_descending;
                  val_ff  <= req_value;
                  k_ff    <= '0;
                  if (bad) begin
                     state_ff <= S_ERR;
                  end else begin
                     case (req_op) inside
                        gte_pkg::CMD_SET, gte_pkg::CMD_CLEAR: state_ff <= S_WRITE;
                        gte_pkg::CMD_SUM: begin
                           r_ff     <= req_row_a;
                           c_ff     <= req_col_a;
                           state_ff <= empty_sum ? S_DRAIN : S_SCAN;
                        end
                        gte_pkg::CMD_SEARCH: begin
                           r_ff     <= '0;
                           c_ff     <= '0;
                           state_ff <= S_SCAN;
                        end
                        default: state_ff <= S_SCAN;
                     endcase
                  end
               end
            end
            S_ERR, S_WRITE: begin
               if (status.out_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SCAN: begin
               case (op_ff) inside
                  gte_pkg::CMD_SUM: begin
                     if (c_ff == cb_ff) begin
                        c_ff <= ca_ff;
                        if (r_ff == rb_ff) begin
                           state_ff <= S_DRAIN;
                        end else begin
                           r_ff <= r_ff + 1'b1;
                        end
                     end else begin
                        c_ff <= c_ff + 1'b1;
                     end
                  end
                  gte_pkg::CMD_SEARCH: begin
                     if (c_ff == COL_LAST) begin
                        state_ff <= S_DRAIN;
                     end else begin
                        c_ff <= c_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (k_ff == len_last) begin
                        k_ff     <= '0;
                        state_ff <= S_DRAIN;
                     end else begin
                        k_ff <= k_ff + 1'b1;
                     end
                  end
               endcase
            end
            S_DRAIN: begin
               state_ff <= (op_ff == gte_pkg::CMD_SORT) ? S_SORT : S_EMIT;
            end
            S_SORT: begin
               if (k_ff == SORT_LAST) begin
                  k_ff     <= '0;
                  state_ff <= S_LANE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (status.out_ready) begin
                  if (op_ff == gte_pkg::CMD_SEARCH && r_ff != ROW_LAST) begin
                     r_ff     <= r_ff + 1'b1;
                     c_ff     <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_LANE: begin
               if (status.out_ready) begin
                  if (k_ff == len_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hdl/grid_table_engine_top.sv]
`timescale 1ns / 1ps

// A 10 by 10 grid of signed 16-bit cells, zero after reset, that takes one command
// beat at a time and answers with one or more result beats, the final one marked by
// rsp_last. Set, clear and an index error give a single beat; a range sum, mean,
// minimum or maximum reads each cell from the single-port cell memory; a search
// gives one beat per row; a sort reads the line, runs 10 odd-even compare-exchange
// passes over the line registers, then gives one beat per cycle while the output is
// not stalled. A new command is taken only once the previous one is finished; a last
// result may still sit in the output register while the next command is taken.
module grid_table_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_cmd,
   input  logic [gte_pkg::IDX_W-1:0]           req_row_a,
   input  logic [gte_pkg::IDX_W-1:0]           req_col_a,
   input  logic [gte_pkg::IDX_W-1:0]           req_row_b,
   input  logic [gte_pkg::IDX_W-1:0]           req_col_b,
   input  logic [gte_pkg::IDX_W-1:0]           req_line_index,
   input  logic                                req_line_is_column,
   input  logic                                req_descending,
   input  logic signed [gte_pkg::VAL_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic signed [gte_pkg::RES_W-1:0]    rsp_result_value,
   output logic [gte_pkg::IDX_W-1:0]           rsp_position,
   output logic [gte_pkg::MASK_W-1:0]          rsp_match_mask,
   output logic                                rsp_last
);

   gte_pkg::dp_cmd_type    cmd;
   gte_pkg::dp_status_type status;

   gte_controller u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_row_a         (req_row_a),
      .req_col_a         (req_col_a),
      .req_row_b         (req_row_b),
      .req_col_b         (req_col_b),
      .req_line_index    (req_line_index),
      .req_line_is_column(req_line_is_column),
      .req_descending    (req_descending),
      .req_value         (req_value),
      .status            (status),
      .cmd               (cmd)
   );

   gte_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_value(rsp_result_value),
      .rsp_position    (rsp_position),
      .rsp_match_mask  (rsp_match_mask),
      .rsp_last        (rsp_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command taken while busy");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last)
      else $error("error beat not final");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_result_value == '0 && rsp_match_mask == '0)
      else $error("error beat carries data");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_ready)
      else $error("result overwritten");

endmodule
